>>> design/route_table_with_expiry_core_macros.svh
// ----------------------------------------------------------------------------
// Route table with expiry - assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ROUTE_TABLE_WITH_EXPIRY_CORE_MACROS_SVH
`define ROUTE_TABLE_WITH_EXPIRY_CORE_MACROS_SVH

// same-cycle implication
`define RTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RTE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rte_pkg.sv
// ----------------------------------------------------------------------------
// rte_pkg
// Shared types and constants of the route table with expiry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rte_pkg;

  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned IFACE_W = 32;
  localparam int unsigned COST_W  = 8;
  localparam int unsigned SEQ_W   = 16;
  localparam int unsigned NOW_W   = 62;
  localparam int unsigned LIFE_W  = 40;
  localparam int unsigned EXP_W   = 63;
  localparam int unsigned STAT_W  = 3;

  localparam logic [LIFE_W-1:0] LIFETIME_RST = 40'd120000000000;

  // request opcodes
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_MISS     = 3'd0;
  localparam logic [STAT_W-1:0] ST_HIT      = 3'd1;
  localparam logic [STAT_W-1:0] ST_EXPIRED  = 3'd2;
  localparam logic [STAT_W-1:0] ST_INSERTED = 3'd3;
  localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd4;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd5;

  // fields reported when no live entry is returned
  localparam logic [ADDR_W-1:0]  INV_NEXT_HOP = '1;
  localparam logic [IFACE_W-1:0] INV_IFACE    = '1;
  localparam logic [COST_W-1:0]  INV_COST     = '1;
  localparam logic [SEQ_W-1:0]   INV_SEQ      = '0;

  // one stored route (key lives in its own memory)
  typedef struct packed {
    logic [ADDR_W-1:0]  next_hop;
    logic [IFACE_W-1:0] iface;
    logic [COST_W-1:0]  cost;
    logic [SEQ_W-1:0]   seq;
    logic [EXP_W-1:0]   expiry;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_wr;  // clearing pass write at index
    logic capture;   // request accepted, load it and reset scan flags
    logic scan_rd;   // read key memory at index
    logic fetch;     // read route memory at matched slot
    logic commit;    // apply result, write back, load output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic slot_free; // output register can take a result this cycle
  } sts_t;

endpackage

>>> design/route_table_with_expiry_core.sv
// Route table with expiry: TABLE_ENTRIES-slot table keyed by 48-bit address.
// Flow: key scan one slot per cycle through the key memory read port, then
//   drain, route fetch and commit; commit waits while the result register holds
//   a stalled result, and a new request is taken only after commit.
// Reset: async, active low; then a clearing pass over every slot of the
//   key memory during which requests stall (lifetime writes are taken).
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// route_table_with_expiry_core
// Associative route table with per-entry expiry, add and lookup requests.
// ----------------------------------------------------------------------------
module route_table_with_expiry_core #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // lifetime register write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rte_pkg::LIFE_W-1:0]  cfg_data_i,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [rte_pkg::ADDR_W-1:0]  dest_addr_i,
  input  logic [rte_pkg::ADDR_W-1:0]  next_hop_addr_i,
  input  logic [rte_pkg::IFACE_W-1:0] iface_index_i,
  input  logic [rte_pkg::COST_W-1:0]  path_cost_i,
  input  logic [rte_pkg::SEQ_W-1:0]   seq_number_i,
  input  logic [rte_pkg::NOW_W-1:0]   now_time_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rte_pkg::STAT_W-1:0]  status_o,
  output logic                        found_valid_o,
  output logic [rte_pkg::ADDR_W-1:0]  out_next_hop_o,
  output logic [rte_pkg::IFACE_W-1:0] out_iface_o,
  output logic [rte_pkg::COST_W-1:0]  out_cost_o,
  output logic [rte_pkg::SEQ_W-1:0]   out_seq_o
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  rte_pkg::cmd_t    cmd;
  rte_pkg::sts_t    sts;
  logic [IDX_W-1:0] idx;

  // Lifetime register takes a write on any cycle. Firmware must change it only
  // between requests, not enforced here, so a scan's sum now + lifetime is stable.
  assign cfg_ready_o = 1'b1;

  // Controller: owns the slot counter shared by the clearing pass and the scan.
  // The request channel is open only in its idle state; the result register
  // in the datapath lets a new request enter while the last result waits.
  rte_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .idx_o      (idx)
  );

  // Datapath: key memory (valid bit + key) scanned in slot order, which gives
  // both the matching slot and the lowest free slot in one pass. The route
  // memory is read once at the matched slot; the commit step then compares
  // expiry against now, writes back and loads the result register.
  rte_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .idx_i           (idx),
    .sts_o           (sts),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .op_i            (op_i),
    .dest_addr_i     (dest_addr_i),
    .next_hop_addr_i (next_hop_addr_i),
    .iface_index_i   (iface_index_i),
    .path_cost_i     (path_cost_i),
    .seq_number_i    (seq_number_i),
    .now_time_i      (now_time_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .found_valid_o   (found_valid_o),
    .out_next_hop_o  (out_next_hop_o),
    .out_iface_o     (out_iface_o),
    .out_cost_o      (out_cost_o),
    .out_seq_o       (out_seq_o)
  );

endmodule

>>> design/rte_ctrl.sv
// ----------------------------------------------------------------------------
// rte_ctrl
// Sequencer: clearing pass, key scan, route fetch and commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rte_ctrl #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rte_pkg::sts_t        sts_i,
  output rte_pkg::cmd_t        cmd_o,
  output logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] idx_o
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FETCH  = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             last;

  assign last = (idx_q == IDX_LAST);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (last) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          idx_d         = '0;
          state_d       = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (last) begin
          idx_d   = '0;
          state_d = S_DRAIN;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_FETCH;
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts_i.slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        idx_d   = '0;
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign idx_o      = idx_q;

endmodule

>>> design/rte_dpath.sv
// ----------------------------------------------------------------------------
// rte_dpath
// Key and route memories, scan compare, expiry check and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rte_dpath #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rte_pkg::cmd_t                  cmd_i,
  input  logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] idx_i,
  output rte_pkg::sts_t                  sts_o,
  // config
  input  logic                           cfg_valid_i,
  input  logic [rte_pkg::LIFE_W-1:0]     cfg_data_i,
  // request
  input  logic                           op_i,
  input  logic [rte_pkg::ADDR_W-1:0]     dest_addr_i,
  input  logic [rte_pkg::ADDR_W-1:0]     next_hop_addr_i,
  input  logic [rte_pkg::IFACE_W-1:0]    iface_index_i,
  input  logic [rte_pkg::COST_W-1:0]     path_cost_i,
  input  logic [rte_pkg::SEQ_W-1:0]      seq_number_i,
  input  logic [rte_pkg::NOW_W-1:0]      now_time_i,
  // result
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [rte_pkg::STAT_W-1:0]     status_o,
  output logic                           found_valid_o,
  output logic [rte_pkg::ADDR_W-1:0]     out_next_hop_o,
  output logic [rte_pkg::IFACE_W-1:0]    out_iface_o,
  output logic [rte_pkg::COST_W-1:0]     out_cost_o,
  output logic [rte_pkg::SEQ_W-1:0]      out_seq_o
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned KEY_W = rte_pkg::ADDR_W;

  // {valid, key}
  logic [KEY_W:0]        key_mem [TABLE_ENTRIES];
  rte_pkg::entry_t       data_mem [TABLE_ENTRIES];

  logic [rte_pkg::LIFE_W-1:0] lifetime_q;

  logic                        op_q;
  logic [KEY_W-1:0]            key_q;
  logic [rte_pkg::ADDR_W-1:0]  nh_q;
  logic [rte_pkg::IFACE_W-1:0] iface_q;
  logic [rte_pkg::COST_W-1:0]  cost_q;
  logic [rte_pkg::SEQ_W-1:0]   seq_q;
  logic [rte_pkg::NOW_W-1:0]   now_q;
  logic [rte_pkg::EXP_W-1:0]   exp_new_q;

  logic [KEY_W:0]   key_rd_q;
  logic             rd_chk_q;
  logic [IDX_W-1:0] rd_idx_q;

  logic             hit_q, free_q;
  logic [IDX_W-1:0] hit_idx_q, free_idx_q;

  rte_pkg::entry_t  data_rd_q;

  logic                        out_vld_q;
  logic [rte_pkg::STAT_W-1:0]  res_status;
  logic                        res_found;
  logic                        expired;
  logic                        key_we, data_we;
  logic [IDX_W-1:0]            key_wa, data_wa;
  logic [KEY_W:0]              key_wd;
  rte_pkg::entry_t             data_wd;

  // lifetime register, write channel always ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lifetime_q <= rte_pkg::LIFETIME_RST;
    end else if (cfg_valid_i) begin
      lifetime_q <= cfg_data_i;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_i;
      key_q   <= dest_addr_i;
      nh_q    <= next_hop_addr_i;
      iface_q <= iface_index_i;
      cost_q  <= path_cost_i;
      seq_q   <= seq_number_i;
      now_q   <= now_time_i;
    end
    if (cmd_i.scan_rd) begin
      exp_new_q <= {1'b0, now_q} + {{(rte_pkg::EXP_W - rte_pkg::LIFE_W){1'b0}}, lifetime_q};
    end
  end

  // key memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    if (cmd_i.scan_rd) begin
      key_rd_q <= key_mem[idx_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) begin
      rd_idx_q <= idx_i;
    end
  end

  // scan compare, one entry per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_chk_q <= 1'b0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
    end else begin
      rd_chk_q <= cmd_i.scan_rd;
      if (cmd_i.capture) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (rd_chk_q) begin
        if (key_rd_q[KEY_W] && (key_rd_q[KEY_W-1:0] == key_q) && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (!key_rd_q[KEY_W] && !free_q) begin
          free_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_chk_q && !cmd_i.capture) begin
      if (key_rd_q[KEY_W] && (key_rd_q[KEY_W-1:0] == key_q) && !hit_q) begin
        hit_idx_q <= rd_idx_q;
      end
      if (!key_rd_q[KEY_W] && !free_q) begin
        free_idx_q <= rd_idx_q;
      end
    end
  end

  // route memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_mem[data_wa] <= data_wd;
    end
    if (cmd_i.fetch) begin
      data_rd_q <= data_mem[hit_idx_q];
    end
  end

  assign expired = (data_rd_q.expiry < {1'b0, now_q});

  assign data_wd.next_hop = nh_q;
  assign data_wd.iface    = iface_q;
  assign data_wd.cost     = cost_q;
  assign data_wd.seq      = seq_q;
  assign data_wd.expiry   = exp_new_q;

  // decision and write-back
  always_comb begin
    res_status = rte_pkg::ST_MISS;
    res_found  = 1'b0;
    key_we     = 1'b0;
    key_wa     = idx_i;
    key_wd     = '0;
    data_we    = 1'b0;
    data_wa    = hit_idx_q;
    if (cmd_i.clear_wr) begin
      key_we = 1'b1;
    end else if (cmd_i.commit) begin
      if (op_q == rte_pkg::OP_ADD) begin
        if (hit_q) begin
          res_status = rte_pkg::ST_UPDATED;
          data_we    = 1'b1;
        end else if (free_q) begin
          res_status = rte_pkg::ST_INSERTED;
          key_we     = 1'b1;
          key_wa     = free_idx_q;
          key_wd     = {1'b1, key_q};
          data_we    = 1'b1;
          data_wa    = free_idx_q;
        end else begin
          res_status = rte_pkg::ST_FULL;
        end
      end else begin
        if (!hit_q) begin
          res_status = rte_pkg::ST_MISS;
        end else if (expired) begin
          res_status = rte_pkg::ST_EXPIRED;
          key_we     = 1'b1;
          key_wa     = hit_idx_q;
          key_wd     = {1'b0, key_q};
        end else begin
          res_status = rte_pkg::ST_HIT;
          res_found  = 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_o      <= res_status;
      found_valid_o <= res_found;
      if (res_found) begin
        out_next_hop_o <= data_rd_q.next_hop;
        out_iface_o    <= data_rd_q.iface;
        out_cost_o     <= data_rd_q.cost;
        out_seq_o      <= data_rd_q.seq;
      end else begin
        out_next_hop_o <= rte_pkg::INV_NEXT_HOP;
        out_iface_o    <= rte_pkg::INV_IFACE;
        out_cost_o     <= rte_pkg::INV_COST;
        out_seq_o      <= rte_pkg::INV_SEQ;
      end
    end
  end

  assign out_valid_o     = out_vld_q;
  assign sts_o.slot_free = !out_vld_q || !out_stall_i;

endmodule

>>> design/rte_checker.sv
// ----------------------------------------------------------------------------
// rte_checker
// Port-level checks on the route table core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "route_table_with_expiry_core_macros.svh"

module rte_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [rte_pkg::STAT_W-1:0]  status_o,
  input logic                        found_valid_o,
  input logic [rte_pkg::ADDR_W-1:0]  out_next_hop_o,
  input logic [rte_pkg::IFACE_W-1:0] out_iface_o,
  input logic [rte_pkg::COST_W-1:0]  out_cost_o,
  input logic [rte_pkg::SEQ_W-1:0]   out_seq_o
);

  // a held result stays put
  `RTE_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(out_next_hop_o), "stalled result changed")

  // one request at a time: channel closes right after an accept
  `RTE_ASSERT_NXT(a_one_inflight, in_valid_i && !in_stall_o, in_stall_o, "request channel open after accept")

  // found flag only with a hit
  `RTE_ASSERT_NOW(a_found_hit, out_valid_o && found_valid_o, status_o == rte_pkg::ST_HIT, "found without hit status")

  // anything but a hit carries the invalid route fields
  `RTE_ASSERT_NOW(a_inv_fields, out_valid_o && (status_o != rte_pkg::ST_HIT), !found_valid_o && (out_cost_o == rte_pkg::INV_COST) && (out_seq_o == rte_pkg::INV_SEQ) && (out_iface_o == rte_pkg::INV_IFACE), "invalid fields wrong")

endmodule

bind route_table_with_expiry_core rte_checker u_rte_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .found_valid_o  (found_valid_o),
  .out_next_hop_o (out_next_hop_o),
  .out_iface_o    (out_iface_o),
  .out_cost_o     (out_cost_o),
  .out_seq_o      (out_seq_o)
);
